// ----- sv/icb_pkg.sv -----
// package for the interval complement bitmap
// holds field widths, opcodes and the structs between the sequencer and the word unit
// no dependencies
package icb_pkg;

   localparam int POS_W  = 17;
   localparam int WORD_W = 32;
   localparam int BIT_W  = 5;
   localparam int WIDX_W = POS_W - BIT_W;

   localparam logic [1:0] OP_MARK     = 2'd0;
   localparam logic [1:0] OP_NEXT_GAP = 2'd1;
   localparam logic [1:0] OP_CLEAR    = 2'd2;

   typedef struct packed {
      logic [WORD_W-1:0] data;
      logic [BIT_W-1:0]  off;
      logic              target;
      logic [WIDX_W-1:0] word;
      logic [POS_W-1:0]  len;
      logic [BIT_W-1:0]  mask_lo;
      logic [BIT_W-1:0]  mask_hi;
   } unit_req_type;

   typedef struct packed {
      logic              hit;
      logic [POS_W-1:0]  pos;
      logic              last;
      logic [WORD_W-1:0] mask;
   } unit_rsp_type;

endpackage

// ----- sv/icb_req_if.sv -----
// request channel of the interval complement bitmap
// depends on icb_pkg
interface icb_req_if import icb_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       opcode;
   logic [POS_W-1:0] interval_start;
   logic [POS_W-1:0] interval_end;

   modport source (output valid, opcode, interval_start, interval_end, input ready);
   modport sink   (input valid, opcode, interval_start, interval_end, output ready);
endinterface

// ----- sv/icb_rsp_if.sv -----
// response channel of the interval complement bitmap
// depends on icb_pkg
interface icb_rsp_if import icb_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] gap_start;
   logic [POS_W-1:0] gap_end;
   logic             gap_found;
   logic             range_error;

   modport source (output valid, gap_start, gap_end, gap_found, range_error, input ready);
   modport sink   (input valid, gap_start, gap_end, gap_found, range_error, output ready);
endinterface

// ----- sv/interval_complement_bitmap.sv -----
// interval complement bitmap, top level with the sequencer
// mark: read and write per word touched; next gap: read and evaluate per word scanned, re-evaluate at a gap start
// clear: one bitmap word per cycle, (MAX_LENGTH+31)/32 words (2048 by default)
// reset runs the same clearing pass before the first item is taken
// one result register; the next item can be taken the cycle after the result is taken
// depends on icb_pkg, icb_req_if, icb_rsp_if, icb_word_unit, icb_bitmap_mem
module interval_complement_bitmap import icb_pkg::*; #(
   parameter int MAX_LENGTH = 65536
) (
   input  logic             clock,
   input  logic             reset,
   icb_req_if.sink          req,
   icb_rsp_if.source        rsp,
   input  logic             csr_write_enable,
   input  logic [POS_W-1:0] csr_write_data
);

   localparam int WORD_COUNT = (MAX_LENGTH + WORD_W - 1) / WORD_W;
   localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam logic [31:0]       MAX_LEN_C = 32'(MAX_LENGTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORD_COUNT - 1);
   localparam logic [POS_W-1:0]  LEN_RESET = POS_W'(65536);

   typedef enum logic [5:0] {
      ST_CLEAR    = 6'b000001,
      ST_IDLE     = 6'b000010,
      ST_MARK_RD  = 6'b000100,
      ST_MARK_WR  = 6'b001000,
      ST_GAP_RD   = 6'b010000,
      ST_GAP_EVAL = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [POS_W-1:0]  seq_len_ff;
   logic [POS_W-1:0]  len_eff;
   logic [POS_W-1:0]  scan_ff, scan_in;
   logic [POS_W-1:0]  start_ff, start_in;
   logic [POS_W-1:0]  last_ff, last_in;
   logic [POS_W-1:0]  gs_ff, gs_in;
   logic [WIDX_W-1:0] word_ff, word_in;
   logic [BIT_W-1:0]  off_ff, off_in;
   logic              phase_ff, phase_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic              clr_rsp_ff, clr_rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_gs_ff, rsp_gs_in;
   logic [POS_W-1:0]  rsp_ge_ff, rsp_ge_in;
   logic              rsp_found_ff, rsp_found_in;
   logic              rsp_err_ff, rsp_err_in;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic [WORD_W-1:0] mem_wdata;
   logic [WORD_W-1:0] mem_rdata;
   unit_req_type      unit_req;
   unit_rsp_type      unit_rsp;

   assign len_eff = (32'(seq_len_ff) > MAX_LEN_C) ? MAX_LEN_C[POS_W-1:0] : seq_len_ff;
   assign mem_addr = (state_ff == ST_CLEAR) ? clr_cnt_ff : ADDR_W'(word_ff);

   assign req.ready       = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.gap_start   = rsp_gs_ff;
   assign rsp.gap_end     = rsp_ge_ff;
   assign rsp.gap_found   = rsp_found_ff;
   assign rsp.range_error = rsp_err_ff;

   icb_word_unit u_unit (
      .unit_req (unit_req),
      .unit_rsp (unit_rsp)
   );

   icb_bitmap_mem #(
      .DEPTH  (WORD_COUNT),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      start_in     = start_ff;
      last_in      = last_ff;
      gs_in        = gs_ff;
      word_in      = word_ff;
      off_in       = off_ff;
      phase_in     = phase_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_rsp_in   = clr_rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_gs_in    = rsp_gs_ff;
      rsp_ge_in    = rsp_ge_ff;
      rsp_found_in = rsp_found_ff;
      rsp_err_in   = rsp_err_ff;
      mem_we       = 1'b0;
      mem_wdata    = '0;

      unit_req.data    = mem_rdata;
      unit_req.off     = off_ff;
      unit_req.target  = phase_ff;
      unit_req.word    = word_ff;
      unit_req.len     = len_eff;
      unit_req.mask_lo = (word_ff == start_ff[POS_W-1:BIT_W]) ? start_ff[BIT_W-1:0] : '0;
      unit_req.mask_hi = (word_ff == last_ff[POS_W-1:BIT_W]) ? last_ff[BIT_W-1:0] : '1;

      if (rsp.valid && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (clr_cnt_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
               if (clr_rsp_ff) begin
                  clr_rsp_in   = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_gs_in    = '0;
                  rsp_ge_in    = '0;
                  rsp_found_in = 1'b0;
                  rsp_err_in   = 1'b0;
               end
            end else begin
               clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               rsp_gs_in    = '0;
               rsp_ge_in    = '0;
               rsp_found_in = 1'b0;
               rsp_err_in   = 1'b0;
               case (req.opcode)
                  OP_MARK: begin
                     if (req.interval_end > len_eff) begin
                        rsp_valid_in = 1'b1;
                        rsp_err_in   = 1'b1;
                     end else if (req.interval_start >= req.interval_end) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        start_in = req.interval_start;
                        last_in  = req.interval_end - POS_W'(1);
                        word_in  = req.interval_start[POS_W-1:BIT_W];
                        state_in = ST_MARK_RD;
                     end
                  end
                  OP_NEXT_GAP: begin
                     if (scan_ff >= len_eff) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        word_in  = scan_ff[POS_W-1:BIT_W];
                        off_in   = scan_ff[BIT_W-1:0];
                        phase_in = 1'b0;
                        state_in = ST_GAP_RD;
                     end
                  end
                  OP_CLEAR: begin
                     scan_in    = '0;
                     clr_cnt_in = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_MARK_RD: begin
            state_in = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata | unit_rsp.mask;
            if (word_ff == last_ff[POS_W-1:BIT_W]) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               word_in  = word_ff + WIDX_W'(1);
               state_in = ST_MARK_RD;
            end
         end
         ST_GAP_RD: begin
            state_in = ST_GAP_EVAL;
         end
         ST_GAP_EVAL: begin
            if (!phase_ff) begin
               if (unit_rsp.hit) begin
                  gs_in    = unit_rsp.pos;
                  off_in   = unit_rsp.pos[BIT_W-1:0];
                  phase_in = 1'b1;
               end else if (unit_rsp.last) begin
                  scan_in      = len_eff;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  word_in  = word_ff + WIDX_W'(1);
                  off_in   = '0;
                  state_in = ST_GAP_RD;
               end
            end else begin
               if (unit_rsp.hit || unit_rsp.last) begin
                  scan_in      = unit_rsp.hit ? unit_rsp.pos : len_eff;
                  rsp_gs_in    = gs_ff;
                  rsp_ge_in    = unit_rsp.hit ? unit_rsp.pos : len_eff;
                  rsp_found_in = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  word_in  = word_ff + WIDX_W'(1);
                  off_in   = '0;
                  state_in = ST_GAP_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_ff      <= '0;
         clr_cnt_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seq_len_ff   <= LEN_RESET;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            seq_len_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      start_ff     <= start_in;
      last_ff      <= last_in;
      gs_ff        <= gs_in;
      word_ff      <= word_in;
      off_ff       <= off_in;
      phase_ff     <= phase_in;
      rsp_gs_ff    <= rsp_gs_in;
      rsp_ge_ff    <= rsp_ge_in;
      rsp_found_ff <= rsp_found_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assert property (@(posedge clock) disable iff (reset) req.ready |-> !rsp.valid)
      else $error("request ready while a response is pending");

   assert property (@(posedge clock) disable iff (reset) (req.valid && req.ready) |=> !req.ready)
      else $error("request ready right after an item was taken");

   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || state_ff == ST_MARK_WR))
      else $error("bitmap written outside clear or mark");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MARK_WR |-> word_ff <= last_ff[POS_W-1:BIT_W])
      else $error("mark walked past its last word");

endmodule

// ----- sv/icb_word_unit.sv -----
// shared word unit: first-bit search within one bitmap word and mark mask generation
// depends on icb_pkg
module icb_word_unit import icb_pkg::*; (
   input  unit_req_type unit_req,
   output unit_rsp_type unit_rsp
);

   logic [WORD_W-1:0] vec;
   logic [BIT_W-1:0]  first;
   logic [POS_W-1:0]  pos;
   logic [POS_W:0]    word_end;

   always_comb begin
      vec   = (unit_req.target ? unit_req.data : ~unit_req.data)
              & ({WORD_W{1'b1}} << unit_req.off);
      first = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (vec[i]) begin
            first = BIT_W'(i);
         end
      end
      pos      = {unit_req.word, first};
      word_end = {({1'b0, unit_req.word} + (WIDX_W + 1)'(1)), {BIT_W{1'b0}}};

      unit_rsp.hit  = (|vec) && (pos < unit_req.len);
      unit_rsp.pos  = pos;
      unit_rsp.last = word_end >= {1'b0, unit_req.len};
      unit_rsp.mask = ({WORD_W{1'b1}} << unit_req.mask_lo)
                      & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - unit_req.mask_hi));
   end

endmodule

// ----- sv/icb_bitmap_mem.sv -----
// bitmap storage, one word per address, registered read
// depends on icb_pkg
module icb_bitmap_mem import icb_pkg::*; #(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WORD_W-1:0] wr_data,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- verif/interval_complement_bitmap_tb.sv -----
// testbench for interval_complement_bitmap: directed and random mark, next-gap, clear and unused-opcode items
// checked one by one against a bit-level predictor of the coverage bitmap and scan pointer
// depends on icb_pkg, icb_req_if, icb_rsp_if and the interval_complement_bitmap rtl
module interval_complement_bitmap_tb;
   import icb_pkg::*;

   localparam int MAX_LENGTH = 65536;
   localparam int POS_MAX = (1 << POS_W) - 1;
   localparam int ITEM_TARGET = 1150;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [POS_W-1:0] gap_start;
      logic [POS_W-1:0] gap_end;
      logic             gap_found;
      logic             range_error;
   } gap_report_type;

   logic             clock;
   logic             reset;
   logic             csr_write_enable;
   logic [POS_W-1:0] csr_write_data;

   icb_req_if req_ch ();
   icb_rsp_if rsp_ch ();

   interval_complement_bitmap #(.MAX_LENGTH(MAX_LENGTH)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // predictor state
   bit               covered_pos [MAX_LENGTH];
   logic [POS_W-1:0] scan_ptr;
   logic [POS_W-1:0] length_reg;

   gap_report_type expected_reports [$];
   int          error_count;
   int          reports_seen;
   int          items_sent;
   bit          req_held;
   bit          sender_eager;
   bit          receiver_eager;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin : watchdog
      #60_000_000;
      $display("** interval_complement_bitmap: FAILED **");
      $finish;
   end

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("mismatch: %s", msg);
      end
   endfunction

   function automatic gap_report_type predict_report(input logic [1:0] op,
                                                     input logic [POS_W-1:0] ival_start,
                                                     input logic [POS_W-1:0] ival_end);
      gap_report_type rep;
      int unsigned lim;
      int unsigned p;
      rep = '0;
      lim = 32'(length_reg);
      if (lim > 32'(MAX_LENGTH)) lim = 32'(MAX_LENGTH);
      case (op)
         OP_MARK: begin
            if (32'(ival_end) > lim) begin
               rep.range_error = 1'b1;
            end else begin
               for (p = 32'(ival_start); p < 32'(ival_end); p++) covered_pos[p] = 1'b1;
            end
         end
         OP_NEXT_GAP: begin
            p = 32'(scan_ptr);
            while (p < lim && covered_pos[p]) p++;
            if (p < lim) begin
               rep.gap_start = POS_W'(p);
               while (p < lim && !covered_pos[p]) p++;
               rep.gap_end   = POS_W'(p);
               rep.gap_found = 1'b1;
            end
            scan_ptr = POS_W'(p);
         end
         OP_CLEAR: begin
            covered_pos = '{default: 1'b0};
            scan_ptr    = '0;
         end
         default: ;
      endcase
      return rep;
   endfunction

   task automatic lower_request();
      if (req_held) begin
         req_ch.valid <= 1'b0;
         req_held = 1'b0;
      end
   endtask

   task automatic send_item(input logic [1:0] op, input logic [POS_W-1:0] ival_start,
                            input logic [POS_W-1:0] ival_end);
      int idle;
      idle = sender_eager ? 0 : $urandom_range(0, 7);
      if (idle > 0) begin
         lower_request();
         repeat (idle) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.opcode         <= op;
      req_ch.interval_start <= ival_start;
      req_ch.interval_end   <= ival_end;
      req_held = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      expected_reports.push_back(predict_report(op, ival_start, ival_end));
      items_sent++;
   endtask

   task automatic wait_for_reports();
      lower_request();
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_length(input logic [POS_W-1:0] value);
      wait_for_reports();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      length_reg = value;
      csr_write_enable <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [POS_W-1:0] want,
                              input logic [POS_W-1:0] got);
      if (got !== want) begin
         note_error($sformatf("report %0d %s expected %0d got %0d",
                              reports_seen, name, want, got));
      end
   endtask

   initial begin : report_checker
      gap_report_type want;
      int stall;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = receiver_eager ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         if (expected_reports.size() == 0) begin
            note_error($sformatf("report with no item pending: gap %0d..%0d found %b err %b",
                                 rsp_ch.gap_start, rsp_ch.gap_end, rsp_ch.gap_found,
                                 rsp_ch.range_error));
         end else begin
            want = expected_reports.pop_front();
            check_field("gap_start", want.gap_start, rsp_ch.gap_start);
            check_field("gap_end", want.gap_end, rsp_ch.gap_end);
            check_field("gap_found", POS_W'(want.gap_found), POS_W'(rsp_ch.gap_found));
            check_field("range_error", POS_W'(want.range_error), POS_W'(rsp_ch.range_error));
         end
         reports_seen++;
      end
   end

   // reset length: whole bitmap is one gap, then none left; unused op, clear, edge and overrange marks
   task automatic test_reset_defaults();
      send_item(OP_NEXT_GAP, '0, '0);
      send_item(OP_NEXT_GAP, POS_W'(POS_MAX), POS_W'(POS_MAX));
      send_item(OP_UNUSED, POS_W'(POS_MAX), POS_W'(POS_MAX));
      send_item(OP_CLEAR, '0, '0);
      send_item(OP_MARK, POS_W'(MAX_LENGTH - 1), POS_W'(MAX_LENGTH));
      send_item(OP_MARK, '0, POS_W'(MAX_LENGTH + 1));
   endtask

   task automatic test_short_sequence();
      write_length(POS_W'(100));
      send_item(OP_MARK, POS_W'(10), POS_W'(20));
      send_item(OP_MARK, POS_W'(0), POS_W'(1));
      send_item(OP_MARK, POS_W'(99), POS_W'(100));
      send_item(OP_MARK, POS_W'(50), POS_W'(40));
      send_item(OP_MARK, POS_W'(30), POS_W'(30));
      send_item(OP_MARK, POS_W'(5), POS_W'(101));
      send_item(OP_MARK, POS_W'(POS_MAX), '0);
      repeat (4) send_item(OP_NEXT_GAP, '0, '0);
   endtask

   // zero length, oversized length, single position
   task automatic test_length_extremes();
      write_length('0);
      send_item(OP_MARK, '0, '0);
      send_item(OP_MARK, '0, POS_W'(1));
      send_item(OP_NEXT_GAP, '0, '0);
      write_length(POS_W'(POS_MAX));
      send_item(OP_NEXT_GAP, '0, '0);
      send_item(OP_NEXT_GAP, '0, '0);
      send_item(OP_CLEAR, POS_W'(POS_MAX), POS_W'(POS_MAX));
      write_length(POS_W'(1));
      send_item(OP_NEXT_GAP, '0, '0);
   endtask

   task automatic send_random_item(input int lim);
      int r;
      int wide;
      int a;
      int b;
      r = $urandom_range(0, 99);
      a = $urandom_range(0, POS_MAX);
      b = $urandom_range(0, POS_MAX);
      if (r < 50) begin
         a = $urandom_range(0, lim);
         wide = ($urandom_range(0, 3) == 0) ? $urandom_range(0, lim)
                                             : $urandom_range(0, lim / 16 + 1);
         b = (a + wide > lim) ? lim : a + wide;
         send_item(OP_MARK, POS_W'(a), POS_W'(b));
      end else if (r < 56) begin
         b = $urandom_range(lim + 1, POS_MAX);
         send_item(OP_MARK, POS_W'(a), POS_W'(b));
      end else if (r < 62) begin
         send_item(OP_MARK, POS_W'(a), POS_W'(b));
      end else if (r < 94) begin
         send_item(OP_NEXT_GAP, POS_W'(a), POS_W'(b));
      end else if (r < 98) begin
         send_item(OP_CLEAR, POS_W'(a), POS_W'(b));
      end else begin
         send_item(OP_UNUSED, POS_W'(a), POS_W'(b));
      end
   endtask

   // phases of random items, each under a freshly drawn length
   task automatic test_random_traffic();
      int r;
      int len;
      int lim;
      int count;
      int big_phases;
      big_phases = 0;
      while (items_sent < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            len = $urandom_range(1, 700);
         end else if (r < 75) begin
            len = $urandom_range(701, 4096);
         end else if (r < 82) begin
            len = $urandom_range(0, 1);
         end else if (big_phases < 4) begin
            len = (r < 91) ? MAX_LENGTH : $urandom_range(MAX_LENGTH + 1, POS_MAX);
            big_phases++;
         end else begin
            len = $urandom_range(1, 64);
         end
         write_length(POS_W'(len));
         lim = (len > MAX_LENGTH) ? MAX_LENGTH : len;
         count = (lim > 4096) ? 15 : $urandom_range(40, 120);
         sender_eager   = ($urandom_range(0, 3) == 0);
         receiver_eager = ($urandom_range(0, 3) == 0);
         repeat (count) send_random_item(lim);
      end
      wait_for_reports();
   endtask

   initial begin : stimulus
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.opcode         = OP_MARK;
      req_ch.interval_start = '0;
      req_ch.interval_end   = '0;
      csr_write_enable      = 1'b0;
      csr_write_data        = '0;
      covered_pos           = '{default: 1'b0};
      scan_ptr              = '0;
      length_reg            = POS_W'(MAX_LENGTH);
      error_count           = 0;
      reports_seen          = 0;
      items_sent            = 0;
      req_held              = 1'b0;
      sender_eager          = 1'b0;
      receiver_eager        = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_short_sequence();
      test_length_extremes();
      test_random_traffic();

      repeat (64) @(posedge clock);
      if (error_count == 0 && expected_reports.size() == 0) begin
         $display("** interval_complement_bitmap: PASSED **");
      end else begin
         $display("** interval_complement_bitmap: FAILED **");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/icb_pkg.sv
sv/icb_req_if.sv
sv/icb_rsp_if.sv
sv/icb_word_unit.sv
sv/icb_bitmap_mem.sv
sv/interval_complement_bitmap.sv
verif/interval_complement_bitmap_tb.sv
